>>> rtl/fts_pkg.sv
// Shared types, codes and helpers for the fan tachometer speed scanner.
// No dependencies; used by every module in rtl/.
`default_nettype none

package fts_pkg;

    // Fan set scanned in round-robin order
    localparam int FAN_COUNT = 2;
    localparam int FAN_W     = (FAN_COUNT > 1) ? $clog2(FAN_COUNT) : 1;

    // Register reset values
    localparam logic [15:0] CPO_RESET  = 16'd10000;
    localparam logic [31:0] NUM_RESET  = 32'd100000;
    localparam logic [3:0]  MAXP_RESET = 4'd10;
    localparam logic [3:0]  MAXW_RESET = 4'd10;

    // Divider geometry: the divisor never exceeds 65535 + 65536 * 15
    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 20;
    localparam int SPEED_W    = 16;

    // Command codes carried in s_tuser
    localparam logic [1:0] CMD_POLL = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_EDGE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_CPO  = 2'd0;
    localparam logic [1:0] REG_NUM  = 2'd1;
    localparam logic [1:0] REG_MAXP = 2'd2;
    localparam logic [1:0] REG_MAXW = 2'd3;

    typedef enum logic [1:0] {
        DONE_NONE = 2'd0,
        DONE_MEAS = 2'd1,
        DONE_TMO  = 2'd2
    } done_t;

    // Requests from the sequencer to the capture logic
    typedef struct packed {
        logic poll;
        logic tick;
        logic edge_hit;
    } cap_ctrl_t;

    // Capture status seen by the sequencer
    typedef struct packed {
        logic        running;
        done_t       done;
        logic [15:0] captured;
        logic [3:0]  overflows;
    } cap_status_t;

    // A modulus of zero counts as 65536
    function automatic logic [16:0] modulus(input logic [15:0] cpo);
        logic [16:0] m;
        if (cpo == 16'd0)
            m = 17'h10000;
        else
            m = {1'b0, cpo};
        return m;
    endfunction

endpackage

`default_nettype wire

>>> rtl/fts_capture.sv
// Capture counter, overflow and timeout tracking for the current fan.
// Depends on fts_pkg.
`default_nettype none

module fts_capture (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire fts_pkg::cap_ctrl_t  ctrl,
    input  wire logic [15:0]         cpo,
    input  wire logic [3:0]          max_periods,
    input  wire logic [3:0]          max_waits,
    output fts_pkg::cap_status_t     status
);

    logic             running_reg, running_next;
    logic             seen_reg, seen_next;
    logic [3:0]       ovf_reg, ovf_next;
    logic [3:0]       wait_reg, wait_next;
    logic [15:0]      tick_reg, tick_next;
    logic [15:0]      cap_reg, cap_next;
    fts_pkg::done_t   done_reg, done_next;

    logic [16:0]      mod;
    logic [16:0]      tick_inc;
    logic [4:0]       wait_inc;

    assign mod      = fts_pkg::modulus(cpo);
    assign tick_inc = {1'b0, tick_reg} + 17'd1;
    assign wait_inc = {1'b0, wait_reg} + 5'd1;

    always_comb
    begin
        running_next = running_reg;
        seen_next    = seen_reg;
        ovf_next     = ovf_reg;
        wait_next    = wait_reg;
        tick_next    = tick_reg;
        cap_next     = cap_reg;
        done_next    = done_reg;

        if (ctrl.poll)
        begin
            done_next = fts_pkg::DONE_NONE;
            if (!running_reg)
            begin
                tick_next    = 16'd0;
                ovf_next     = 4'd0;
                wait_next    = 4'd0;
                seen_next    = 1'b0;
                running_next = 1'b1;
            end
        end
        else if (ctrl.tick && running_reg)
        begin
            if (tick_inc >= mod)
            begin
                tick_next = 16'd0;
                if (seen_reg)
                begin
                    if (ovf_reg == max_periods)
                    begin
                        running_next = 1'b0;
                        done_next    = fts_pkg::DONE_TMO;
                    end
                    else
                        ovf_next = ovf_reg + 4'd1;
                end
                else
                begin
                    if (wait_inc > {1'b0, max_waits})
                    begin
                        running_next = 1'b0;
                        done_next    = fts_pkg::DONE_TMO;
                    end
                    // hold at 15 rather than wrap
                    wait_next = wait_inc[4] ? 4'd15 : wait_inc[3:0];
                end
            end
            else
                tick_next = tick_inc[15:0];
        end
        else if (ctrl.edge_hit && running_reg)
        begin
            if (!seen_reg)
            begin
                tick_next = 16'd0;
                seen_next = 1'b1;
            end
            else
            begin
                cap_next     = tick_reg;
                running_next = 1'b0;
                done_next    = fts_pkg::DONE_MEAS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            seen_reg    <= 1'b0;
            ovf_reg     <= 4'd0;
            wait_reg    <= 4'd0;
            tick_reg    <= 16'd0;
            cap_reg     <= 16'd0;
            done_reg    <= fts_pkg::DONE_NONE;
        end
        else
        begin
            running_reg <= running_next;
            seen_reg    <= seen_next;
            ovf_reg     <= ovf_next;
            wait_reg    <= wait_next;
            tick_reg    <= tick_next;
            cap_reg     <= cap_next;
            done_reg    <= done_next;
        end
    end

    assign status.running   = running_reg;
    assign status.done      = done_reg;
    assign status.captured  = cap_reg;
    assign status.overflows = ovf_reg;

`ifndef SYNTHESIS
    // A finished measurement always leaves the counter stopped
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg != fts_pkg::DONE_NONE) |-> !running_reg)
        else $error("capture running with a finished measurement");
`endif

endmodule

`default_nettype wire

>>> rtl/fts_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on fts_pkg for operand widths.
`default_nettype none

module fts_divider (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [fts_pkg::DIVIDEND_W-1:0]    dividend,
    input  wire logic [fts_pkg::DIVISOR_W-1:0]     divisor,
    output logic                                   busy,
    output logic                                   done,
    output logic [fts_pkg::DIVIDEND_W-1:0]         quotient
);

    localparam int DW = fts_pkg::DIVIDEND_W;
    localparam int VW = fts_pkg::DIVISOR_W;
    localparam int CW = $clog2(DW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [VW-1:0] div_reg;
    logic [VW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;

    logic [VW:0]   shifted;
    logic [VW:0]   diff;
    logic          ge;

    // quo_reg shifts the dividend out at the top and the quotient in at the bottom
    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign ge      = shifted >= {1'b0, div_reg};
    assign diff    = shifted - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[VW-1:0] : shifted[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef SYNTHESIS
    // Completion follows the last step of a running division
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("divider done without a running division");
`endif

endmodule

`default_nettype wire

>>> rtl/fan_tach_speed_scanner_top.sv
// Fan tachometer speed scanner: stream ports, configuration registers and sequencer.
// Depends on fts_pkg, fts_capture and fts_divider.
`default_nettype none

// Measures tach periods one fan at a time in round-robin order. Timer ticks and tach
// edges produce no result. A poll that finds a finished measurement emits the fan
// index and speed = numerator / (count + modulus * overflows), then moves to the next
// fan and restarts capture; a timed-out measurement reports speed 0, a zero divisor
// or a quotient above 65535 reports 65535 with the saturated flag. A measured poll
// runs the shared restoring divider, one quotient bit per cycle, and holds the input
// off through ST_DIV and ST_OUT, including any wait for the result register to drain;
// timed-out and zero-divisor polls hold it off through ST_OUT only. Ticks and edges
// are accepted while a result waits in the result register.

module fan_tach_speed_scanner_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] edge_fan, [7:1] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] cmd
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [0] fan_index, [16:1] speed, [23:17] zero
    output logic [1:0]       m_tuser,   // [0] timed_out, [1] saturated
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    localparam int FW = fts_pkg::FAN_W;
    localparam int SW = fts_pkg::SPEED_W;
    localparam int DW = fts_pkg::DIVIDEND_W;
    localparam int VW = fts_pkg::DIVISOR_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t  state_reg;

    logic [15:0] cpo_reg;
    logic [31:0] num_reg;
    logic [3:0]  maxp_reg;
    logic [3:0]  maxw_reg;

    logic [FW-1:0] fan_reg;
    logic [FW-1:0] res_fan_reg;
    logic [SW-1:0] res_speed_reg;
    logic          res_tmo_reg;
    logic          res_sat_reg;

    logic          m_tvalid_reg;
    logic [23:0]   m_tdata_reg;
    logic [1:0]    m_tuser_reg;

    fts_pkg::cap_ctrl_t   ctrl;
    fts_pkg::cap_status_t status;

    logic          accept;
    logic          poll_done;
    logic [20:0]   prod;
    logic [20:0]   div_sum;
    logic          div_zero;
    logic          div_start;
    logic          div_busy;
    logic          div_done;
    logic [DW-1:0] quotient;
    logic          q_over;
    logic          out_free;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpo_reg  <= fts_pkg::CPO_RESET;
            num_reg  <= fts_pkg::NUM_RESET;
            maxp_reg <= fts_pkg::MAXP_RESET;
            maxw_reg <= fts_pkg::MAXW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fts_pkg::REG_CPO:  cpo_reg  <= cfg_wdata[15:0];
                fts_pkg::REG_NUM:  num_reg  <= cfg_wdata;
                fts_pkg::REG_MAXP: maxp_reg <= cfg_wdata[3:0];
                fts_pkg::REG_MAXW: maxw_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // ---------------- request decode ----------------
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign ctrl.poll     = accept && (s_tuser == fts_pkg::CMD_POLL);
    assign ctrl.tick     = accept && (s_tuser == fts_pkg::CMD_TICK);
    assign ctrl.edge_hit = accept && (s_tuser == fts_pkg::CMD_EDGE)
                           && (FW'(s_tdata[0]) == fan_reg);

    assign poll_done = ctrl.poll && (status.done != fts_pkg::DONE_NONE);

    // Divisor from the finished measurement, before the poll restarts capture
    assign prod      = 21'(fts_pkg::modulus(cpo_reg)) * 21'(status.overflows);
    assign div_sum   = prod + {5'd0, status.captured};
    assign div_zero  = (status.captured == 16'd0) && (status.overflows == 4'd0);
    assign div_start = poll_done && (status.done == fts_pkg::DONE_MEAS) && !div_zero;

    fts_capture u_capture (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .cpo         (cpo_reg),
        .max_periods (maxp_reg),
        .max_waits   (maxw_reg),
        .status      (status)
    );

    fts_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (div_sum[VW-1:0]),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    assign q_over   = (quotient[DW-1:SW] != '0);
    assign out_free = !m_tvalid_reg || m_tready;

    // ---------------- sequencer and result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fan_reg       <= '0;
            res_fan_reg   <= '0;
            res_speed_reg <= '0;
            res_tmo_reg   <= 1'b0;
            res_sat_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            m_tuser_reg   <= '0;
        end
        else
        begin
            // ST_OUT reloads the result register itself
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT))
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (poll_done)
                    begin
                        res_fan_reg <= fan_reg;
                        if (fan_reg == FW'(fts_pkg::FAN_COUNT - 1))
                            fan_reg <= '0;
                        else
                            fan_reg <= fan_reg + 1'b1;

                        if (status.done == fts_pkg::DONE_TMO)
                        begin
                            res_speed_reg <= '0;
                            res_tmo_reg   <= 1'b1;
                            res_sat_reg   <= 1'b0;
                            state_reg     <= ST_OUT;
                        end
                        else if (div_zero)
                        begin
                            res_speed_reg <= '1;
                            res_tmo_reg   <= 1'b0;
                            res_sat_reg   <= 1'b1;
                            state_reg     <= ST_OUT;
                        end
                        else
                        begin
                            res_tmo_reg <= 1'b0;
                            state_reg   <= ST_DIV;
                        end
                    end
                end

                ST_DIV:
                begin
                    if (div_done)
                    begin
                        res_speed_reg <= q_over ? '1 : quotient[SW-1:0];
                        res_sat_reg   <= q_over;
                        state_reg     <= ST_OUT;
                    end
                end

                ST_OUT:
                begin
                    // hold until the result register is free
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {7'd0, res_speed_reg, res_fan_reg[0]};
                        m_tuser_reg  <= {res_sat_reg, res_tmo_reg};
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // A division is only launched while the divider is free
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // A saturated result always carries full-scale speed
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[16:1] == 16'hFFFF))
        else $error("saturated result without full-scale speed");

    // A timed-out result carries zero speed and no saturation
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> ((m_tdata[16:1] == 16'd0) && !m_tuser[1]))
        else $error("timed-out result with speed or saturation");

    // The divider only runs while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == ST_DIV))
        else $error("divider busy outside the divide state");
`endif

endmodule

`default_nettype wire
